@@ hdl/clp_pkg.sv @@
`default_nettype none
package clp_pkg;

	localparam int VAL_W = 15;
	localparam int PH_W  = 3;

	localparam logic [VAL_W-1:0] SAT_MAX = 15'd32767;

	// number scanner phases
	localparam logic [PH_W-1:0] PH_BLANK = 3'd0;
	localparam logic [PH_W-1:0] PH_INT   = 3'd1;
	localparam logic [PH_W-1:0] PH_TENTH = 3'd2;
	localparam logic [PH_W-1:0] PH_FRAC  = 3'd3;
	localparam logic [PH_W-1:0] PH_STOP  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_PAIR  = 2'd0;
	localparam logic [1:0] KIND_DIGIT = 2'd1;
	localparam logic [1:0] KIND_CMD   = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// limits in tenths for the single number
	localparam logic [VAL_W-1:0] LIM_NINE  = 15'd90;
	localparam logic [VAL_W-1:0] LIM_SEVEN = 15'd70;

	typedef struct packed {
		logic [PH_W-1:0]  phase;
		logic [VAL_W-1:0] value;
		logic             excess;
		logic             rest;
	} scan_t;

	// integer part of a value in tenths known to be at most 90: t * 205 / 2048
	function automatic logic [3:0] tenths_to_digit(input logic [VAL_W-1:0] t);
		logic [14:0] p;
		p = 15'(t[6:0]) * 15'd205;
		return p[14:11];
	endfunction

endpackage
`default_nettype wire

@@ hdl/clp_ifs.sv @@
`default_nettype none
interface clp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [14:0] x_tenths;
	logic [14:0] y_tenths;
	logic [3:0]  digit;

	modport source (output valid, output kind, output x_tenths, output y_tenths,
		output digit, input ready);
	modport sink   (input valid, input kind, input x_tenths, input y_tenths,
		input digit, output ready);
endinterface
`default_nettype wire

@@ hdl/clp_scan.sv @@
`default_nettype none
module clp_scan (
	input  wire clp_pkg::scan_t cur,
	input  wire logic [7:0]     ch,
	output clp_pkg::scan_t      nxt
);

	logic        is_digit;
	logic        is_blank;
	logic [3:0]  d;
	logic [18:0] int_sum;
	logic [15:0] frac_sum;

	assign is_digit = (ch >= clp_pkg::CH_ZERO) && (ch <= clp_pkg::CH_NINE);
	assign is_blank = (ch == clp_pkg::CH_SP) || (ch == clp_pkg::CH_TAB);
	assign d        = is_digit ? ch[3:0] : 4'd0;
	assign int_sum  = 19'(cur.value) * 19'd10 + 19'(d) * 19'd10;
	assign frac_sum = 16'(cur.value) + 16'(d);

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			clp_pkg::PH_BLANK, clp_pkg::PH_INT: begin
				if (cur.phase == clp_pkg::PH_BLANK && is_blank) begin
					nxt = cur;
				end else if (is_digit) begin
					nxt.phase = clp_pkg::PH_INT;
					if (int_sum > 19'(clp_pkg::SAT_MAX)) begin
						nxt.value  = clp_pkg::SAT_MAX;
						nxt.excess = 1'b1;
					end else begin
						nxt.value = int_sum[14:0];
					end
				end else if (ch == clp_pkg::CH_POINT) begin
					nxt.phase = clp_pkg::PH_TENTH;
				end else begin
					nxt.phase = clp_pkg::PH_STOP;
				end
			end
			clp_pkg::PH_TENTH: begin
				if (is_digit) begin
					nxt.phase = clp_pkg::PH_FRAC;
					if (frac_sum > 16'(clp_pkg::SAT_MAX)) begin
						nxt.value  = clp_pkg::SAT_MAX;
						nxt.excess = 1'b1;
					end else begin
						nxt.value = frac_sum[14:0];
					end
				end else begin
					nxt.phase = clp_pkg::PH_STOP;
				end
			end
			clp_pkg::PH_FRAC: begin
				if (is_digit) begin
					if (d != 4'd0) begin
						nxt.rest = 1'b1;
					end
				end else begin
					nxt.phase = clp_pkg::PH_STOP;
				end
			end
			default: begin
				nxt.phase = clp_pkg::PH_STOP;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/coord_line_parser_core.sv @@
`default_nettype none
// Line parser for received text: takes one byte per beat and gives at most one result
// beat when a line ends on LF or CR. It sustains one byte per clock cycle unless a
// terminator waits while the sink stalls a full output register; a byte is held in the
// input register, and the result of a terminator is written to the output register. A
// single shared number scanner (a multiply by ten and a saturating add) between those
// two registers sets the clock rate. The output register holds a result while the sink
// stalls, and the input side keeps taking bytes whenever the byte in hand can move on.
// No clearing pass is needed after reset. LINE_LEN sets how many bytes of a line are
// kept (LINE_LEN-1).
module coord_line_parser_core #(
	parameter int LINE_LEN = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	clp_byte_if.sink      rx,
	clp_result_if.source  result
);

	localparam int CW = $clog2(LINE_LEN);
	localparam logic [CW-1:0] CNT_MAX = CW'(LINE_LEN - 1);

	logic [7:0]    byte_s1;
	logic          vld_s1;
	logic [CW-1:0] cnt_q;
	logic          comma_q;
	logic          ended_q;
	clp_pkg::scan_t first_q;
	clp_pkg::scan_t second_q;
	clp_pkg::scan_t scan_cur;
	clp_pkg::scan_t scan_nxt;

	logic        out_vld_q;
	logic [1:0]  kind_q;
	logic [14:0] x_q;
	logic [14:0] y_q;
	logic [3:0]  digit_q;

	logic        adv;
	logic        is_term;
	logic        le9;
	logic        le7;
	logic        emit;
	logic [1:0]  kind_nx;
	logic [14:0] y_nx;
	logic [3:0]  digit_nx;

	localparam clp_pkg::scan_t SCAN_CLR = '{
		phase: clp_pkg::PH_BLANK, value: '0, excess: 1'b0, rest: 1'b0};

	// hold only a terminator while the result register is full and the sink stalls
	assign adv      = vld_s1 && (!is_term || !out_vld_q || result.ready);
	assign rx.ready = !vld_s1 || adv;
	assign is_term  = (byte_s1 == clp_pkg::CH_LF) || (byte_s1 == clp_pkg::CH_CR);
	assign scan_cur = comma_q ? second_q : first_q;

	clp_scan u_scan (
		.cur (scan_cur),
		.ch  (byte_s1),
		.nxt (scan_nxt)
	);

	// single number limits compared as exact decimals
	assign le9 = !first_q.excess && ((first_q.value < clp_pkg::LIM_NINE) ||
		(first_q.value == clp_pkg::LIM_NINE && !first_q.rest));
	assign le7 = (first_q.value < clp_pkg::LIM_SEVEN) ||
		(first_q.value == clp_pkg::LIM_SEVEN && !first_q.rest);
	assign emit = (cnt_q != '0) && (comma_q || le9);

	always_comb begin
		if (comma_q) begin
			kind_nx  = clp_pkg::KIND_PAIR;
			y_nx     = second_q.value;
			digit_nx = 4'd0;
		end else begin
			kind_nx  = le7 ? clp_pkg::KIND_CMD : clp_pkg::KIND_DIGIT;
			y_nx     = '0;
			digit_nx = clp_pkg::tenths_to_digit(first_q.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			comma_q  <= 1'b0;
			ended_q  <= 1'b0;
			first_q  <= SCAN_CLR;
			second_q <= SCAN_CLR;
		end else if (adv) begin
			if (is_term) begin
				cnt_q    <= '0;
				comma_q  <= 1'b0;
				ended_q  <= 1'b0;
				first_q  <= SCAN_CLR;
				second_q <= SCAN_CLR;
			end else if (cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
				if (!ended_q) begin
					priority if (byte_s1 == clp_pkg::CH_NUL) begin
						ended_q <= 1'b1;
					end else if (!comma_q && byte_s1 == clp_pkg::CH_COMMA) begin
						comma_q <= 1'b1;
					end else if (!comma_q) begin
						first_q <= scan_nxt;
					end else begin
						second_q <= scan_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && is_term) begin
			out_vld_q <= emit;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_term && emit) begin
			kind_q  <= kind_nx;
			x_q     <= first_q.value;
			y_q     <= y_nx;
			digit_q <= digit_nx;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.kind     = kind_q;
	assign result.x_tenths = x_q;
	assign result.y_tenths = y_q;
	assign result.digit    = digit_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("line byte count past limit");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_term |=> cnt_q == '0 && !comma_q && !ended_q)
		else $error("terminator did not clear line state");

	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		first_q.phase == clp_pkg::PH_BLANK |-> first_q.value == '0 && !first_q.excess)
		else $error("value gathered before any digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && kind_q != clp_pkg::KIND_PAIR |->
			y_q == '0 && x_q <= clp_pkg::LIM_NINE && digit_q <= 4'd9)
		else $error("single number result out of range");

endmodule
`default_nettype wire
